>>> rtl/acrr_pkg.sv
package acrr_pkg;

	localparam int RING_DEPTH_DEF = 128;
	localparam int DELAY_DEF      = 64;
	localparam int MAX_RUN_DEF    = 32;

	localparam int SAMPLE_W  = 16;
	localparam int THR_W     = 15;
	localparam int MRL_W     = 6;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CLIP_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN_LENGTH = 1'd1;

	localparam logic [THR_W-1:0] CLIP_THRESHOLD_RST = 15'd32440;
	localparam logic [MRL_W-1:0] MAX_RUN_LENGTH_RST = 6'd32;

	// 0.999, 0.5 and 0.12 in Q1.15
	localparam logic [16:0] SAFE_PEAK    = 17'd32735;
	localparam logic [16:0] HALF_LEVEL   = 17'd16384;
	localparam logic [16:0] HEADROOM_MAX = 17'd3932;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RDL,
		S_RDR,
		S_GETR,
		S_DIV,
		S_K0,
		S_K1,
		S_K2,
		S_K3,
		S_ORD,
		S_OLD
	} state_t;

	// quarter-wave sine, Q15, 33 points over 0..pi/2
	function automatic logic [15:0] sine_quarter(input logic [5:0] idx);
		logic [15:0] v;
		unique case (idx)
			6'd0:  v = 16'd0;
			6'd1:  v = 16'd1608;
			6'd2:  v = 16'd3212;
			6'd3:  v = 16'd4808;
			6'd4:  v = 16'd6393;
			6'd5:  v = 16'd7962;
			6'd6:  v = 16'd9512;
			6'd7:  v = 16'd11039;
			6'd8:  v = 16'd12540;
			6'd9:  v = 16'd14010;
			6'd10: v = 16'd15447;
			6'd11: v = 16'd16846;
			6'd12: v = 16'd18205;
			6'd13: v = 16'd19520;
			6'd14: v = 16'd20788;
			6'd15: v = 16'd22006;
			6'd16: v = 16'd23170;
			6'd17: v = 16'd24279;
			6'd18: v = 16'd25330;
			6'd19: v = 16'd26320;
			6'd20: v = 16'd27245;
			6'd21: v = 16'd28106;
			6'd22: v = 16'd28898;
			6'd23: v = 16'd29622;
			6'd24: v = 16'd30273;
			6'd25: v = 16'd30852;
			6'd26: v = 16'd31357;
			6'd27: v = 16'd31786;
			6'd28: v = 16'd32138;
			6'd29: v = 16'd32413;
			6'd30: v = 16'd32610;
			6'd31: v = 16'd32729;
			default: v = 16'd32768;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/acrr_if.sv
interface acrr_in_if;
	logic valid;
	logic ready;
	logic signed [acrr_pkg::SAMPLE_W-1:0] in_sample;
	modport source (output valid, output in_sample, input ready);
	modport sink (input valid, input in_sample, output ready);
endinterface

interface acrr_out_if;
	logic valid;
	logic ready;
	logic signed [acrr_pkg::SAMPLE_W-1:0] out_sample;
	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

>>> rtl/audio_clip_run_repair.sv
// Without a repair an accepted item passes through the states ORD and OLD to the
// output register; with a repair the states RDL, RDR and GETR, the reciprocal
// divider in DIV and the loop K0..K3, run once per repaired sample, come first.
// One item at a time: a new transfer is taken only in IDLE, after the previous
// item is through and the output register has room for its result.
// Reset: asynchronous, active low; a clearing pass over the whole ring
// zeroes it before the first item is taken.
module audio_clip_run_repair #(
	parameter int RING_DEPTH = acrr_pkg::RING_DEPTH_DEF,
	parameter int DELAY      = acrr_pkg::DELAY_DEF,
	parameter int MAX_RUN    = acrr_pkg::MAX_RUN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	acrr_in_if.sink                         audio,
	acrr_out_if.source                      repaired,
	input  logic                            cfg_we,
	input  logic [acrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acrr_pkg::CFG_W-1:0]      cfg_data
);

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int CW  = $clog2(MAX_RUN + 2);
	localparam int FW  = $clog2(DELAY + 1);
	localparam int LW  = (CW > acrr_pkg::MRL_W) ? CW : acrr_pkg::MRL_W;
	localparam int OFF = DELAY % RING_DEPTH;

	acrr_pkg::state_t state_q, state_d;

	logic [acrr_pkg::SAMPLE_W-1:0] mem [RING_DEPTH];
	logic [acrr_pkg::SAMPLE_W-1:0] rdata_q;
	logic                          mem_we;
	logic [AW-1:0]                 waddr, raddr;
	logic [acrr_pkg::SAMPLE_W-1:0] wdata;

	logic [acrr_pkg::THR_W-1:0] thr_q;
	logic [acrr_pkg::MRL_W-1:0] mrl_q;

	logic [AW-1:0] clr_addr_q, pos_q, pos_next, rp, rp_q, run_start_q, rep_start_q;
	logic [AW-1:0] right_pos_q, left_pos, kpos_q;
	logic [FW-1:0] fill_q;
	logic          first_seen_q, in_run_q, from_first_q, pend_q, zero_q, go_q;
	logic [CW-1:0] run_len_q, rep_n_q, den_q, k_q, rem_q, racc_q;
	logic [16:0]   q0_q, qacc_q;
	logic [4:0]    div_cnt_q;

	logic signed [15:0] left_q, right_q;
	logic [11:0]        head_q;
	logic               bump_q, clean_q;
	logic [15:0]        t_s1;
	logic signed [33:0] prod_s2, prod_s3;
	logic [15:0]        sa_s2;
	logic [20:0]        snum_s2;
	logic [27:0]        bprod_s3;
	logic signed [15:0] val16;
	logic [15:0]        out_q;
	logic               out_valid_q;

	logic               accept;
	logic signed [16:0] xe;
	logic [16:0]        xmag;
	logic               clipped;
	logic [LW-1:0]      limit, len_ext, mrl_ext;
	logic               run_ok;

	assign accept = audio.valid && audio.ready;
	assign xe     = {audio.in_sample[15], audio.in_sample};
	assign xmag   = audio.in_sample[15] ? 17'(-xe) : 17'(xe);
	assign clipped = xmag >= {2'b00, thr_q};
	assign mrl_ext = LW'(mrl_q);
	assign len_ext = LW'(run_len_q);
	assign limit   = (mrl_ext < LW'(MAX_RUN)) ? mrl_ext : LW'(MAX_RUN);
	assign run_ok  = !clipped && in_run_q && len_ext >= LW'(2) && len_ext <= limit &&
		!from_first_q;

	assign pos_next = (pos_q == AW'(RING_DEPTH - 1)) ? '0 : pos_q + AW'(1);
	assign rp = (pos_q >= AW'(OFF)) ? pos_q - AW'(OFF) : pos_q + AW'(RING_DEPTH - OFF);
	assign left_pos = (rep_start_q == '0) ? AW'(RING_DEPTH - 1) : rep_start_q - AW'(1);

	assign audio.ready         = (state_q == acrr_pkg::S_IDLE);
	assign repaired.valid      = out_valid_q;
	assign repaired.out_sample = out_q;

	// divider step: one quotient bit of 65536 / (n+1) per cycle
	logic [CW:0] div_r2;
	logic        div_ge;
	assign div_r2 = {rem_q, (div_cnt_q == 5'd0)};
	assign div_ge = div_r2 >= {1'b0, den_q};

	// next sample position t_k kept as quotient and remainder of an accumulator
	logic [CW:0] acc_rs;
	logic        acc_wrap;
	logic [16:0] acc_qn;
	assign acc_rs   = {1'b0, racc_q} + {1'b0, rem_q};
	assign acc_wrap = acc_rs >= {1'b0, den_q};
	assign acc_qn   = qacc_q + q0_q + 17'(acc_wrap);

	// sine lookup over the folded phase
	logic [15:0] sin_u;
	logic [5:0]  sin_i, sin_i1;
	logic [15:0] sin_a, sin_b;
	logic [15:0] sine_v;
	assign sin_u  = (t_s1 <= 16'd32768) ? t_s1 : 16'(17'd65536 - {1'b0, t_s1});
	assign sin_i  = sin_u[15:10];
	assign sin_i1 = (sin_i >= 6'd32) ? 6'd32 : sin_i + 6'd1;
	assign sin_a  = acrr_pkg::sine_quarter(sin_i);
	assign sin_b  = acrr_pkg::sine_quarter(sin_i1);
	assign sine_v = sa_s2 + 16'((snum_s2 + 21'd512) >> 10);

	// headroom and bump enable from the two neighbors
	logic [16:0] lmag, rmag, peak, hdiff;
	logic        same_sign, near_peak;
	assign lmag = left_q[15] ? 17'(-{left_q[15], left_q}) : 17'({left_q[15], left_q});
	assign rmag = right_q[15] ? 17'(-{right_q[15], right_q}) : 17'({right_q[15], right_q});
	assign peak = (lmag > rmag) ? lmag : rmag;
	assign hdiff = (peak >= acrr_pkg::SAFE_PEAK) ? 17'd0 : acrr_pkg::SAFE_PEAK - peak;
	assign same_sign = (!left_q[15] && !right_q[15]) ||
		(left_q <= 16'sd0 && right_q <= 16'sd0);
	assign near_peak = (lmag >= acrr_pkg::HALF_LEVEL) && (rmag >= acrr_pkg::HALF_LEVEL);

	// interpolated value with bump and clamp
	logic signed [33:0] line_full;
	logic signed [19:0] line_off, bump_v, val;
	assign line_full = (prod_s3 + 34'sd32768) >>> 16;
	assign line_off  = 20'(line_full);
	assign bump_v    = bump_q ? (left_q[15] ? -20'(signed'({1'b0, 13'((bprod_s3 + 28'd16384) >> 15)}))
		: 20'(signed'({1'b0, 13'((bprod_s3 + 28'd16384) >> 15)}))) : 20'sd0;
	assign val = 20'(left_q) + line_off + bump_v;
	assign val16 = (val > 20'sd32735) ? 16'sd32735 :
		(val < -20'sd32735) ? -16'sd32735 : 16'(val);

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		waddr   = pos_q;
		wdata   = audio.in_sample;
		raddr   = rp_q;
		unique case (state_q)
			acrr_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_addr_q;
				wdata  = '0;
				if (clr_addr_q == AW'(RING_DEPTH - 1))
					state_d = acrr_pkg::S_IDLE;
			end
			acrr_pkg::S_IDLE: begin
				if (accept) begin
					mem_we  = 1'b1;
					state_d = pend_q ? acrr_pkg::S_RDL : acrr_pkg::S_ORD;
				end
			end
			acrr_pkg::S_RDL: begin
				raddr   = left_pos;
				state_d = acrr_pkg::S_RDR;
			end
			acrr_pkg::S_RDR: begin
				raddr   = right_pos_q;
				state_d = acrr_pkg::S_GETR;
			end
			acrr_pkg::S_GETR: state_d = acrr_pkg::S_DIV;
			acrr_pkg::S_DIV: begin
				if (div_cnt_q == 5'd16)
					state_d = acrr_pkg::S_K0;
			end
			acrr_pkg::S_K0: state_d = acrr_pkg::S_K1;
			acrr_pkg::S_K1: state_d = acrr_pkg::S_K2;
			acrr_pkg::S_K2: state_d = acrr_pkg::S_K3;
			acrr_pkg::S_K3: begin
				mem_we  = 1'b1;
				waddr   = kpos_q;
				wdata   = val16;
				state_d = (k_q == rep_n_q - CW'(1)) ? acrr_pkg::S_ORD : acrr_pkg::S_K0;
			end
			acrr_pkg::S_ORD: state_d = acrr_pkg::S_OLD;
			acrr_pkg::S_OLD: begin
				if (!out_valid_q || repaired.ready)
					state_d = acrr_pkg::S_IDLE;
			end
			default: state_d = acrr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= acrr_pkg::S_CLEAR;
		else
			state_q <= state_d;
	end

	// ring memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= acrr_pkg::CLIP_THRESHOLD_RST;
			mrl_q <= acrr_pkg::MAX_RUN_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acrr_pkg::REG_CLIP_THRESHOLD: thr_q <= cfg_data;
				acrr_pkg::REG_MAX_RUN_LENGTH: mrl_q <= cfg_data[acrr_pkg::MRL_W-1:0];
				default: ;
			endcase
		end
	end

	// run tracking, fill count and item positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			pos_q        <= '0;
			fill_q       <= '0;
			first_seen_q <= 1'b0;
			in_run_q     <= 1'b0;
			from_first_q <= 1'b0;
			run_start_q  <= '0;
			run_len_q    <= '0;
			pend_q       <= 1'b0;
			rep_start_q  <= '0;
			rep_n_q      <= '0;
			zero_q       <= 1'b0;
			go_q         <= 1'b0;
			right_pos_q  <= '0;
			rp_q         <= '0;
			clean_q      <= 1'b0;
		end else begin
			if (state_q == acrr_pkg::S_CLEAR)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (accept) begin
				pos_q        <= pos_next;
				rp_q         <= rp;
				right_pos_q  <= (pos_q == '0) ? AW'(RING_DEPTH - 1) : pos_q - AW'(1);
				clean_q      <= !clipped;
				go_q         <= pend_q;
				first_seen_q <= 1'b1;
				pend_q       <= run_ok;
				if (fill_q < FW'(DELAY)) begin
					zero_q <= 1'b1;
					fill_q <= fill_q + FW'(1);
				end else begin
					zero_q <= 1'b0;
				end
				if (clipped) begin
					if (!in_run_q) begin
						in_run_q     <= 1'b1;
						run_start_q  <= pos_q;
						run_len_q    <= CW'(1);
						from_first_q <= !first_seen_q;
					end else if (run_len_q < CW'(MAX_RUN + 1)) begin
						run_len_q <= run_len_q + CW'(1);
					end
				end else if (in_run_q) begin
					if (run_ok) begin
						rep_start_q <= run_start_q;
						rep_n_q     <= run_len_q;
					end
					in_run_q <= 1'b0;
				end
			end
		end
	end

	// repair datapath: neighbors, divider, per-sample stages
	always_ff @(posedge clk) begin
		unique case (state_q)
			acrr_pkg::S_RDR: left_q <= rdata_q;
			acrr_pkg::S_GETR: begin
				right_q   <= rdata_q;
				den_q     <= rep_n_q + CW'(1);
				rem_q     <= '0;
				q0_q      <= '0;
				div_cnt_q <= '0;
				qacc_q    <= '0;
				k_q       <= '0;
				kpos_q    <= rep_start_q;
			end
			acrr_pkg::S_DIV: begin
				rem_q     <= div_ge ? CW'(div_r2 - {1'b0, den_q}) : CW'(div_r2);
				q0_q      <= {q0_q[15:0], div_ge};
				div_cnt_q <= div_cnt_q + 5'd1;
				racc_q    <= den_q >> 1;
				head_q    <= (hdiff > acrr_pkg::HEADROOM_MAX) ? 12'(acrr_pkg::HEADROOM_MAX)
					: 12'(hdiff);
				bump_q    <= same_sign && near_peak && clean_q && (hdiff != 17'd0);
			end
			acrr_pkg::S_K0: begin
				racc_q <= acc_wrap ? CW'(acc_rs - {1'b0, den_q}) : CW'(acc_rs);
				qacc_q <= acc_qn;
				t_s1   <= acc_qn[15:0];
			end
			acrr_pkg::S_K1: begin
				prod_s2 <= 34'(17'(signed'({right_q[15], right_q}) - signed'({left_q[15], left_q})))
					* 34'(signed'({1'b0, t_s1}));
				sa_s2   <= sin_a;
				snum_s2 <= 21'(sin_b - sin_a) * 21'(sin_u[9:0]);
			end
			acrr_pkg::S_K2: begin
				prod_s3  <= prod_s2;
				bprod_s3 <= head_q * sine_v;
			end
			acrr_pkg::S_K3: begin
				k_q    <= k_q + CW'(1);
				kpos_q <= (kpos_q == AW'(RING_DEPTH - 1)) ? '0 : kpos_q + AW'(1);
			end
			default: ;
		endcase
	end

	// output register: hold until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (state_q == acrr_pkg::S_OLD && (!out_valid_q || repaired.ready)) begin
				out_valid_q <= 1'b1;
				out_q       <= zero_q ? '0 : rdata_q;
			end else if (repaired.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == acrr_pkg::S_CLEAR |-> !repaired.valid)
		else $error("output valid during clearing pass");
	a_repair_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == acrr_pkg::S_RDL |-> go_q && rep_n_q >= CW'(2) && rep_n_q <= CW'(MAX_RUN))
		else $error("repair started with bad run length");
	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == acrr_pkg::S_K3 |-> k_q < rep_n_q)
		else $error("repair loop ran past run length");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !audio.ready)
		else $error("item taken while previous item in work");
`endif

endmodule
